// ===== rtl/fltw_pkg.sv =====
// shared types and constants for the four-level page table walker
// used by fltw_walk and four_level_page_table_walker; no dependencies
package fltw_pkg;

  localparam int unsigned VaWidth     = 48;
  localparam int unsigned PaWidth     = 52;
  localparam int unsigned EntryWidth  = 64;
  localparam int unsigned IndexBits   = 9;
  localparam int unsigned OffsetBits  = 12;
  localparam int unsigned Levels      = 4;
  localparam int unsigned LevelWidth  = 2;
  localparam int unsigned EntryPresentBit = 0;
  localparam int unsigned EntryLargeBit   = 7;

  localparam logic [LevelWidth-1:0] LevelTop  = LevelWidth'(0);
  localparam logic [LevelWidth-1:0] LevelLast = LevelWidth'(Levels - 1);

  typedef enum logic {
    KIND_TRANSLATE = 1'b0,
    KIND_RESPONSE  = 1'b1
  } in_kind_e;

  typedef enum logic {
    RES_READ = 1'b0,
    RES_DONE = 1'b1
  } res_kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_LARGE_PAGE  = 2'd2
  } status_e;

  typedef struct packed {
    in_kind_e                kind;
    logic [VaWidth-1:0]      virt_addr;
    logic [EntryWidth-1:0]   read_data;
  } in_item_t;

  typedef struct packed {
    res_kind_e               result_kind;
    logic [PaWidth-1:0]      address;
    status_e                 status;
  } res_item_t;

  typedef struct packed {
    logic                    emit;
    logic                    busy;
    res_item_t               item;
  } step_t;

  // table index of the virtual address for a given level, top level first
  function automatic logic [IndexBits-1:0] table_index(
    input logic [VaWidth-1:0]    va,
    input logic [LevelWidth-1:0] level
  );
    logic [IndexBits-1:0] idx;
    idx = '0;
    case (level)
      2'd0:    idx = va[OffsetBits + 3*IndexBits +: IndexBits];
      2'd1:    idx = va[OffsetBits + 2*IndexBits +: IndexBits];
      2'd2:    idx = va[OffsetBits + IndexBits +: IndexBits];
      default: idx = va[OffsetBits +: IndexBits];
    endcase
    return idx;
  endfunction

  // entry address: table frame joined with index times eight
  function automatic logic [PaWidth-1:0] entry_address(
    input logic [PaWidth-1:0]    base,
    input logic [VaWidth-1:0]    va,
    input logic [LevelWidth-1:0] level
  );
    return {base[PaWidth-1:OffsetBits], table_index(va, level), 3'b000};
  endfunction

endpackage

// ===== rtl/fltw_walk.sv =====
// walk state and single-step translation logic for one item
// depends on fltw_pkg
module fltw_walk import fltw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  in_item_t            item_i,
  input  logic [PaWidth-1:0]  root_base_i,
  output step_t               step_o
);

  logic                    busy_q, busy_d;
  logic [LevelWidth-1:0]   level_q, level_d;
  logic [VaWidth-1:0]      saved_q, saved_d;
  logic [LevelWidth-1:0]   level_next;
  step_t                   res;

  assign level_next = level_q + LevelWidth'(1);

  always_comb begin
    res       = '0;
    res.busy  = busy_q;
    busy_d    = busy_q;
    level_d   = level_q;
    saved_d   = saved_q;
    res.item.result_kind = RES_READ;
    res.item.status      = ST_OK;
    if (item_i.kind == KIND_TRANSLATE) begin
      if (!busy_q) begin
        res.emit         = 1'b1;
        res.item.address = entry_address(root_base_i, item_i.virt_addr, LevelTop);
        busy_d  = 1'b1;
        level_d = LevelTop;
        saved_d = item_i.virt_addr;
      end
    end else if (busy_q) begin
      res.emit = 1'b1;
      if (!item_i.read_data[EntryPresentBit]) begin
        res.item.result_kind = RES_DONE;
        res.item.status      = ST_NOT_PRESENT;
        busy_d  = 1'b0;
        level_d = LevelTop;
      end else if (level_q != LevelTop && level_q != LevelLast &&
                   item_i.read_data[EntryLargeBit]) begin
        // large pages are refused at the middle levels
        res.item.result_kind = RES_DONE;
        res.item.status      = ST_LARGE_PAGE;
        busy_d  = 1'b0;
        level_d = LevelTop;
      end else if (level_q == LevelLast) begin
        res.item.result_kind = RES_DONE;
        res.item.address     = {item_i.read_data[PaWidth-1:OffsetBits],
                                saved_q[OffsetBits-1:0]};
        busy_d  = 1'b0;
        level_d = LevelTop;
      end else begin
        res.item.address = entry_address(item_i.read_data[PaWidth-1:0], saved_q,
                                         level_next);
        level_d = level_next;
      end
    end
  end

  assign step_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= LevelTop;
    end else if (step_i) begin
      busy_q  <= busy_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      saved_q <= saved_d;
    end
  end

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// Four-level page table walker: translates a 48-bit virtual address through four
// levels of 512-entry tables, one level step per item. Each item (translate request
// or memory response) passes an input register, one step of masking and comparing,
// and a result register; an item can be taken every cycle unless m_axis_tready holds
// the result register; only the step stage touches the walk state. Requests while a
// walk is running and responses while idle are dropped without a result. The table
// root must be written over the cfg port while no item is in flight; not enforced here.
// depends on fltw_pkg and fltw_walk
module four_level_page_table_walker import fltw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // translate requests and memory responses
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [111:0]        s_axis_tdata,   // virt_addr [47:0], read_data [111:48]
  input  logic [0:0]          s_axis_tuser,   // kind [0]
  // read requests and finished translations
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [55:0]         m_axis_tdata,   // address [51:0], status [53:52], zero pad
  output logic [0:0]          m_axis_tuser,   // result_kind [0]
  // root table base
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PaWidth-1:0]  cfg_data_i
);

  logic                in_valid_q;
  in_item_t            in_q;
  logic                out_valid_q;
  res_item_t           out_q;
  logic [PaWidth-1:0]  root_base_q;
  logic                advance;
  step_t               step;

  // stage moves on when the result register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_base_q <= '0;
    end else if (cfg_valid_i) begin
      root_base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.kind      <= in_kind_e'(s_axis_tuser[0]);
      in_q.virt_addr <= s_axis_tdata[VaWidth-1:0];
      in_q.read_data <= s_axis_tdata[VaWidth +: EntryWidth];
    end
  end

  fltw_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .root_base_i (root_base_q),
    .step_o      (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step.emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.emit) begin
      out_q <= step.item;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tdata  = {2'b00, out_q.status, out_q.address};

  a_done_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step.emit && step.item.result_kind == RES_DONE |=> !step.busy)
    else $error("walk still busy after a finished translation");

  a_request_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.kind == KIND_TRANSLATE && !step.busy |=> step.busy)
    else $error("accepted request did not start a walk");

  a_failure_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.emit && step.item.status != ST_OK |-> step.item.address == '0)
    else $error("failed translation carries a nonzero address");

  a_read_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.emit && step.item.result_kind == RES_READ |-> step.item.status == ST_OK)
    else $error("read request carries an error status");

endmodule
